// File: sv/bc5_pkg.sv
package bc5_pkg;

  // one channel of one pixel: endpoints and its palette index
  typedef struct packed {
    logic [7:0] e0;
    logic [7:0] e1;
    logic [2:0] idx;
  } chan_t;

  // pixel beat from the block sequencer into the pixel pipeline
  typedef struct packed {
    chan_t       red;
    chan_t       grn;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } pix_t;

  // how a palette entry is finished from its numerator
  typedef enum logic [2:0] {
    PK_RAW,
    PK_DIV7,
    PK_DIV5,
    PK_ZERO,
    PK_FULL
  } pal_kind_t;

  typedef struct packed {
    pal_kind_t   kind;
    logic [10:0] num;
  } pal_num_t;

  // integer square root state: remainder and partial root
  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] root;
  } sq_t;

  // reciprocal multipliers, exact for numerators below 2048
  localparam logic [12:0] RECIP7 = 13'd4682;
  localparam logic [12:0] RECIP5 = 13'd6554;
  localparam logic [15:0] RAD_FULL = 16'd65025;

  // weighted endpoint sum for one palette entry
  function automatic pal_num_t pal_num(input chan_t c);
    pal_num_t   res;
    logic [2:0] c0;
    logic [2:0] c1;
    logic [11:0] sum;
    c0  = 3'd0;
    c1  = 3'd0;
    res.kind = PK_RAW;
    res.num  = 11'd0;
    if (c.idx == 3'd0) begin
      res.num = {3'b000, c.e0};
    end else if (c.idx == 3'd1) begin
      res.num = {3'b000, c.e1};
    end else if (c.e0 > c.e1) begin
      c0  = 3'd0 - c.idx;  // 8 - idx
      c1  = c.idx - 3'd1;
      sum = 12'(c0 * c.e0) + 12'(c1 * c.e1);
      res.kind = PK_DIV7;
      res.num  = sum[10:0];
    end else if (c.idx == 3'd6) begin
      res.kind = PK_ZERO;
    end else if (c.idx == 3'd7) begin
      res.kind = PK_FULL;
    end else begin
      c0  = 3'd6 - c.idx;
      c1  = c.idx - 3'd1;
      sum = 12'(c0 * c.e0) + 12'(c1 * c.e1);
      res.kind = PK_DIV5;
      res.num  = sum[10:0];
    end
    return res;
  endfunction

  // final palette value, truncating division by reciprocal multiply
  function automatic logic [7:0] pal_val(input pal_num_t p);
    logic [23:0] prod;
    logic [7:0]  res;
    prod = 24'd0;
    case (p.kind)
      PK_RAW: res = p.num[7:0];
      PK_DIV7: begin
        prod = 24'(p.num * RECIP7);
        res  = prod[22:15];
      end
      PK_DIV5: begin
        prod = 24'(p.num * RECIP5);
        res  = prod[22:15];
      end
      PK_ZERO: res = 8'd0;
      PK_FULL: res = 8'd255;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // |2v - 255| without a subtractor
  function automatic logic [7:0] abs_dev(input logic [7:0] v);
    return v[7] ? {v[6:0], 1'b1} : ~{v[6:0], 1'b0};
  endfunction

  // one digit of the bitwise square root
  function automatic sq_t sq_step(input sq_t s, input logic [16:0] bitv);
    sq_t         res;
    logic [16:0] trial;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      res.rem  = s.rem - trial;
      res.root = (s.root >> 1) + bitv;
    end else begin
      res.rem  = s.rem;
      res.root = s.root >> 1;
    end
    return res;
  endfunction

endpackage

// File: sv/bc5_blk_seq.sv
module bc5_blk_seq
  import bc5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] red_bits,
  input  logic [63:0] green_bits,
  input  logic [9:0]  block_col,
  input  logic [9:0]  block_row,
  output logic        pix_valid,
  input  logic        pix_ready,
  output pix_t        pix
);

  logic [7:0]  red_e0_r, red_e1_r, grn_e0_r, grn_e1_r;
  logic [47:0] red_idx_r, grn_idx_r;
  logic [9:0]  col_r, row_r;
  logic [3:0]  cnt_r;
  logic        blk_v_r;
  logic        fire;
  logic        take;

  // one pixel leaves per cycle while pix_ready is high; next block loads as the last pixel leaves
  assign fire      = blk_v_r && pix_ready;
  assign in_ready  = !blk_v_r || (pix_ready && cnt_r == 4'd15);
  assign take      = in_valid && in_ready;
  assign pix_valid = blk_v_r;

  // current pixel view
  assign pix.red.e0  = red_e0_r;
  assign pix.red.e1  = red_e1_r;
  assign pix.red.idx = red_idx_r[2:0];
  assign pix.grn.e0  = grn_e0_r;
  assign pix.grn.e1  = grn_e1_r;
  assign pix.grn.idx = grn_idx_r[2:0];
  assign pix.row     = {row_r, cnt_r[3:2]};
  assign pix.col     = {col_r, cnt_r[1:0]};
  assign pix.last    = (cnt_r == 4'd15);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_v_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else if (take) begin
      blk_v_r <= 1'b1;
      cnt_r   <= 4'd0;
    end else if (fire) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        blk_v_r <= 1'b0;
      end
    end
  end

  // block payload, index words shift down one pixel per beat
  always_ff @(posedge clk) begin
    if (take) begin
      red_e0_r  <= red_bits[7:0];
      red_e1_r  <= red_bits[15:8];
      red_idx_r <= red_bits[63:16];
      grn_e0_r  <= green_bits[7:0];
      grn_e1_r  <= green_bits[15:8];
      grn_idx_r <= green_bits[63:16];
      col_r     <= block_col;
      row_r     <= block_row;
    end else if (fire) begin
      red_idx_r <= {3'b000, red_idx_r[47:3]};
      grn_idx_r <= {3'b000, grn_idx_r[47:3]};
    end
  end

endmodule

// File: sv/bc5_pix_pipe.sv
module bc5_pix_pipe
  import bc5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [12:0] width,
  input  logic        pix_valid,
  output logic        pix_ready,
  input  pix_t        pix,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pixel_address,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_pixel
);

  logic [6:1] v_r;
  logic [6:1] en;

  // stage 1: palette numerators
  pal_num_t    s1_rn_r, s1_gn_r;
  logic [11:0] s1_row_r, s1_col_r;
  logic        s1_last_r;
  // stage 2: palette values, row times width
  logic [7:0]  s2_r_r, s2_g_r;
  logic [24:0] s2_prod_r;
  logic [11:0] s2_col_r;
  logic        s2_last_r;
  // stage 3: squared deviations, address
  logic [15:0] s3_a2_r, s3_b2_r;
  logic [7:0]  s3_r_r, s3_g_r;
  logic [23:0] s3_addr_r;
  logic        s3_last_r;
  // stage 4: clamped radicand
  sq_t         s4_sq_r;
  logic [7:0]  s4_r_r, s4_g_r;
  logic [23:0] s4_addr_r;
  logic        s4_last_r;
  // stage 5: upper root digits
  sq_t         s5_sq_r;
  logic [7:0]  s5_r_r, s5_g_r;
  logic [23:0] s5_addr_r;
  logic        s5_last_r;

  logic [16:0] s4_sum;
  sq_t         s5_sq_nxt, s6_sq_nxt;
  logic [8:0]  z_sum;

  // a stage advances when empty or when the next one advances
  assign en[6] = !v_r[6] || out_ready;
  assign en[5] = !v_r[5] || en[6];
  assign en[4] = !v_r[4] || en[5];
  assign en[3] = !v_r[3] || en[4];
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign pix_ready = en[1];
  assign out_valid = v_r[6];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= pix_valid;
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
      if (en[5]) v_r[5] <= v_r[4];
      if (en[6]) v_r[6] <= v_r[5];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_rn_r   <= pal_num(pix.red);
      s1_gn_r   <= pal_num(pix.grn);
      s1_row_r  <= pix.row;
      s1_col_r  <= pix.col;
      s1_last_r <= pix.last;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_r_r    <= pal_val(s1_rn_r);
      s2_g_r    <= pal_val(s1_gn_r);
      s2_prod_r <= 25'(s1_row_r * width);
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a2_r   <= 16'(abs_dev(s2_r_r) * abs_dev(s2_r_r));
      s3_b2_r   <= 16'(abs_dev(s2_g_r) * abs_dev(s2_g_r));
      s3_r_r    <= s2_r_r;
      s3_g_r    <= s2_g_r;
      s3_addr_r <= s2_prod_r[23:0] + {12'd0, s2_col_r};
      s3_last_r <= s2_last_r;
    end
  end

  // stage 4: radicand, negative clamps to zero
  assign s4_sum = {1'b0, s3_a2_r} + {1'b0, s3_b2_r};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sq_r.root <= 17'd0;
      if (s4_sum > {1'b0, RAD_FULL}) begin
        s4_sq_r.rem <= 17'd0;
      end else begin
        s4_sq_r.rem <= {1'b0, RAD_FULL} - s4_sum;
      end
      s4_r_r    <= s3_r_r;
      s4_g_r    <= s3_g_r;
      s4_addr_r <= s3_addr_r;
      s4_last_r <= s3_last_r;
    end
  end

  // root digits for bit weights 2^14 .. 2^8
  always_comb begin
    s5_sq_nxt = s4_sq_r;
    for (int k = 0; k < 4; k++) begin
      s5_sq_nxt = sq_step(s5_sq_nxt, 17'(17'd1 << (14 - 2 * k)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_sq_r   <= s5_sq_nxt;
      s5_r_r    <= s4_r_r;
      s5_g_r    <= s4_g_r;
      s5_addr_r <= s4_addr_r;
      s5_last_r <= s4_last_r;
    end
  end

  // root digits for bit weights 2^6 .. 2^0
  always_comb begin
    s6_sq_nxt = s5_sq_r;
    for (int k = 0; k < 4; k++) begin
      s6_sq_nxt = sq_step(s6_sq_nxt, 17'(17'd1 << (6 - 2 * k)));
    end
  end

  assign z_sum = {1'b0, s6_sq_nxt.root[7:0]} + 9'd255;

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_blue_out      <= z_sum[8:1];
      out_red_out       <= s5_r_r;
      out_green_out     <= ~s5_g_r;
      out_pixel_address <= s5_addr_r;
      out_last_pixel    <= s5_last_r;
    end
  end

endmodule

// File: sv/bc5_normal_block_decode.sv
// Two-channel (red/green) normal-map block decoder. Each accepted beat is one
// 4x4 compressed block; it produces 16 pixel beats in raster order, each with
// its frame address, red, inverted green and a reconstructed Z in blue, and
// last_pixel set on the sixteenth. The block sequencer issues one pixel per
// cycle while the pixel pipeline accepts, and the next block is taken in the
// same cycle its predecessor's last pixel is issued, so blocks stream with no
// gap. The pixel pipeline has six register stages (palette numerator, palette
// divide and row multiply, squares and address add, radicand, two stages of
// square-root digits). Output back-pressure stalls the pipeline stage by
// stage; bubbles are squeezed out. cfg_wdata sets the frame width used for
// addresses (reset 1024, saturated at MAX_DIM); write it only while idle.
module bc5_normal_block_decode
  import bc5_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_red_bits,
  input  logic [63:0] in_green_bits,
  input  logic [9:0]  in_block_col,
  input  logic [9:0]  in_block_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pixel_address,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_pixel
);

  logic [12:0] image_width_r;
  logic [12:0] width_eff;
  logic        pix_valid;
  logic        pix_ready;
  pix_t        pix;

  // width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 13'd1024;
    end else if (cfg_we) begin
      image_width_r <= cfg_wdata;
    end
  end

  // saturate width at the frame bound
  assign width_eff = (32'(image_width_r) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : image_width_r;

  bc5_blk_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red_bits   (in_red_bits),
    .green_bits (in_green_bits),
    .block_col  (in_block_col),
    .block_row  (in_block_row),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix)
  );

  bc5_pix_pipe u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .width             (width_eff),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix               (pix),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_last_pixel    (out_last_pixel)
  );

endmodule
